[sv/lqtl_pkg.sv]
// Package with shared types and constants for the line and quoted-token lexer.
`timescale 1ns / 1ps

package lqtl_pkg;

  // Result kinds.
  localparam logic [1:0] K_BYTE = 2'd0;
  localparam logic [1:0] K_TEND = 2'd1;
  localparam logic [1:0] K_LEND = 2'd2;
  localparam logic [1:0] K_LONG = 2'd3;

  // Lexer modes.
  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_BARE = 2'd1;
  localparam logic [1:0] M_QUOT = 2'd2;
  localparam logic [1:0] M_ESC  = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;

  // Configuration register width and the smallest effective line limit.
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned MIN_LIMIT = 16;

  // Most results one input byte can cause.
  localparam int unsigned MAX_RES = 3;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       quoted;
    logic       last;
  } result_t;

  // Lexer state apart from the line length.
  typedef struct packed {
    logic [1:0] lex_mode;
    logic       quote_kind;
    logic       held_cr;
  } lex_state_t;

endpackage

[sv/lqtl_step.sv]
// Combinational lexer step: one byte and the current state give next state and results.
`timescale 1ns / 1ps

module lqtl_step #(
  parameter int unsigned LW = 11,
  parameter int unsigned CW = 11
) (
  input  lqtl_pkg::lex_state_t           st_i,
  input  logic [LW-1:0]                  len_i,
  input  logic [CW-1:0]                  limit_i,
  input  logic [7:0]                     byte_i,
  output lqtl_pkg::lex_state_t           st_o,
  output logic [LW-1:0]                  len_o,
  output lqtl_pkg::result_t [2:0]        res_o,
  output logic [1:0]                     cnt_o
);

  // Outcome of lexing one content byte.
  typedef struct packed {
    logic [1:0]        lex_mode;
    logic              quote_kind;
    logic              emit;
    lqtl_pkg::result_t res;
  } lex_out_t;

  // Lex one non-LF byte against the token state.
  function automatic lex_out_t lex_content(input logic [1:0] mode, input logic qk,
                                           input logic [7:0] c);
    lex_out_t   o;
    logic       delim;
    logic [7:0] close_q;
    logic [7:0] tc;
    o          = '0;
    o.lex_mode = mode;
    o.quote_kind = qk;
    delim      = (c == lqtl_pkg::CH_SPACE) || (c == lqtl_pkg::CH_TAB);
    close_q    = qk ? lqtl_pkg::CH_SQ : lqtl_pkg::CH_DQ;
    tc         = c;
    case (mode)
      lqtl_pkg::M_IDLE: begin
        if (!delim) begin
          if ((c == lqtl_pkg::CH_DQ) || (c == lqtl_pkg::CH_SQ)) begin
            o.lex_mode   = lqtl_pkg::M_QUOT;
            o.quote_kind = (c == lqtl_pkg::CH_SQ);
          end else begin
            o.lex_mode = lqtl_pkg::M_BARE;
            o.emit     = 1'b1;
            o.res      = '{kind: lqtl_pkg::K_BYTE, out_byte: c, quoted: 1'b0, last: 1'b0};
          end
        end
      end
      lqtl_pkg::M_BARE: begin
        o.emit = 1'b1;
        if (delim) begin
          o.lex_mode = lqtl_pkg::M_IDLE;
          o.res      = '{kind: lqtl_pkg::K_TEND, out_byte: 8'd0, quoted: 1'b0, last: 1'b0};
        end else begin
          o.res      = '{kind: lqtl_pkg::K_BYTE, out_byte: c, quoted: 1'b0, last: 1'b0};
        end
      end
      lqtl_pkg::M_QUOT: begin
        if (c == close_q) begin
          o.emit     = 1'b1;
          o.lex_mode = lqtl_pkg::M_IDLE;
          o.res      = '{kind: lqtl_pkg::K_TEND, out_byte: 8'd0, quoted: 1'b1, last: 1'b0};
        end else if (c == lqtl_pkg::CH_BSL) begin
          o.lex_mode = lqtl_pkg::M_ESC;
        end else begin
          o.emit = 1'b1;
          o.res  = '{kind: lqtl_pkg::K_BYTE, out_byte: c, quoted: 1'b1, last: 1'b0};
        end
      end
      default: begin
        if (c == lqtl_pkg::CH_N) begin
          tc = lqtl_pkg::CH_LF;
        end else if (c == lqtl_pkg::CH_R) begin
          tc = lqtl_pkg::CH_CR;
        end
        o.emit     = 1'b1;
        o.lex_mode = lqtl_pkg::M_QUOT;
        o.res      = '{kind: lqtl_pkg::K_BYTE, out_byte: tc, quoted: 1'b1, last: 1'b0};
      end
    endcase
    return o;
  endfunction

  lqtl_pkg::lex_state_t     st;
  logic [LW-1:0]            len;
  lqtl_pkg::result_t [2:0]  res;
  logic [1:0]               cnt;
  lex_out_t                 lo_cr;
  lex_out_t                 lo_b;

  // Abort check, then line end or up to two content bytes (a released CR and this byte).
  always_comb begin
    st    = st_i;
    len   = len_i;
    res   = '0;
    cnt   = 2'd0;
    lo_cr = '0;
    lo_b  = '0;

    // Line too long: report and start the line over with this byte.
    if (CW'(len) >= limit_i) begin
      res[cnt] = '{kind: lqtl_pkg::K_LONG, out_byte: 8'd0, quoted: 1'b0, last: 1'b0};
      cnt      = cnt + 2'd1;
      st       = '0;
      len      = '0;
    end

    if (byte_i == lqtl_pkg::CH_LF) begin
      // Close any open token, then mark the line end.
      if (st.lex_mode == lqtl_pkg::M_BARE) begin
        res[cnt] = '{kind: lqtl_pkg::K_TEND, out_byte: 8'd0, quoted: 1'b0, last: 1'b0};
        cnt      = cnt + 2'd1;
      end else if (st.lex_mode == lqtl_pkg::M_QUOT) begin
        res[cnt] = '{kind: lqtl_pkg::K_TEND, out_byte: 8'd0, quoted: 1'b1, last: 1'b0};
        cnt      = cnt + 2'd1;
      end else if (st.lex_mode == lqtl_pkg::M_ESC) begin
        res[cnt] = '{kind: lqtl_pkg::K_BYTE, out_byte: lqtl_pkg::CH_BSL, quoted: 1'b1,
                     last: 1'b0};
        cnt      = cnt + 2'd1;
        res[cnt] = '{kind: lqtl_pkg::K_TEND, out_byte: 8'd0, quoted: 1'b1, last: 1'b0};
        cnt      = cnt + 2'd1;
      end
      res[cnt] = '{kind: lqtl_pkg::K_LEND, out_byte: 8'd0, quoted: 1'b0, last: 1'b0};
      cnt      = cnt + 2'd1;
      st       = '0;
      len      = '0;
    end else begin
      // A held CR that is not followed by LF becomes content.
      if (st.held_cr) begin
        st.held_cr    = 1'b0;
        lo_cr         = lex_content(st.lex_mode, st.quote_kind, lqtl_pkg::CH_CR);
        st.lex_mode   = lo_cr.lex_mode;
        st.quote_kind = lo_cr.quote_kind;
        if (lo_cr.emit) begin
          res[cnt] = lo_cr.res;
          cnt      = cnt + 2'd1;
        end
      end
      if (byte_i == lqtl_pkg::CH_CR) begin
        st.held_cr = 1'b1;
      end else begin
        lo_b          = lex_content(st.lex_mode, st.quote_kind, byte_i);
        st.lex_mode   = lo_b.lex_mode;
        st.quote_kind = lo_b.quote_kind;
        if (lo_b.emit) begin
          res[cnt] = lo_b.res;
          cnt      = cnt + 2'd1;
        end
      end
      len = len + LW'(1);
    end

    // Flag the last result of this byte.
    if (cnt != 2'd0) begin
      res[cnt - 2'd1].last = 1'b1;
    end
  end

  assign st_o  = st;
  assign len_o = len;
  assign res_o = res;
  assign cnt_o = cnt;

endmodule

[sv/line_and_quoted_token_lexer.sv]
// Top level of the line and quoted-token lexer: input register, lexer step, result group.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata[7:0] = in_byte
//  out_    | master    | out_tvalid/out_tready| out_tdata[7:0] = out_byte,
//          |           |                      | out_tuser[2:0] = kind[1:0], quoted; tlast = last
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_data[10:0] = line_limit
//
// A byte is registered on input and lexed from that register into a group of up to
// three results. The group drains one result per cycle while out_tready is high; the next
// byte is lexed only once the group is empty or its last result is leaving.
// Bytes that give no result still pass through the lexer stage.
// rst_n clears the lexer state and empties both stages; line_limit returns to MAX_LINE.
// An output stall holds the group; the input register still accepts a byte while it is empty.
`timescale 1ns / 1ps

module line_and_quoted_token_lexer #(
  parameter int unsigned MAX_LINE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic [2:0]  out_tuser,   // [1:0] kind, [2] quoted
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data     // [10:0] line_limit
);

  localparam int unsigned LW = $clog2(MAX_LINE + 1);
  localparam int unsigned CW = (LW > lqtl_pkg::CFG_W) ? LW : lqtl_pkg::CFG_W;

  logic                     in_valid_r;
  logic [7:0]               in_byte_r;
  lqtl_pkg::lex_state_t     st_r;
  lqtl_pkg::lex_state_t     st_nxt;
  logic [LW-1:0]            len_r;
  logic [LW-1:0]            len_nxt;
  logic [CW-1:0]            limit_r;
  logic [CW-1:0]            limit_nxt;
  lqtl_pkg::result_t [2:0]  res;
  logic [1:0]               res_cnt;
  lqtl_pkg::result_t [2:0]  grp_r;
  logic [1:0]               rem_r;
  logic                     out_fire;
  logic                     can_load;
  logic                     process;

  // Handshake decisions.
  assign out_fire  = out_tvalid && out_tready;
  assign can_load  = (rem_r == 2'd0) || ((rem_r == 2'd1) && out_tready);
  assign process   = in_valid_r && can_load;
  assign in_tready = !in_valid_r || process;
  assign cfg_ready = 1'b1;

  // Clamp a written limit into the legal range.
  always_comb begin
    limit_nxt = CW'(cfg_data);
    if (limit_nxt < CW'(lqtl_pkg::MIN_LIMIT)) begin
      limit_nxt = CW'(lqtl_pkg::MIN_LIMIT);
    end else if (limit_nxt > CW'(MAX_LINE)) begin
      limit_nxt = CW'(MAX_LINE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CW'(MAX_LINE);
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= limit_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (process) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Lexer step.
  lqtl_step #(
    .LW (LW),
    .CW (CW)
  ) u_step (
    .st_i    (st_r),
    .len_i   (len_r),
    .limit_i (limit_r),
    .byte_i  (in_byte_r),
    .st_o    (st_nxt),
    .len_o   (len_nxt),
    .res_o   (res),
    .cnt_o   (res_cnt)
  );

  // Lexer state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      len_r <= '0;
    end else if (process) begin
      st_r  <= st_nxt;
      len_r <= len_nxt;
    end
  end

  // Result group: loaded with a byte's results, drained from slot zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (process) begin
      rem_r <= res_cnt;
    end else if (out_fire) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      grp_r <= res;
    end else if (out_fire) begin
      grp_r[0] <= grp_r[1];
      grp_r[1] <= grp_r[2];
    end
  end

  // Output channel.
  assign out_tvalid = (rem_r != 2'd0);
  assign out_tdata  = grp_r[0].out_byte;
  assign out_tuser  = {grp_r[0].quoted, grp_r[0].kind};
  assign out_tlast  = grp_r[0].last;

endmodule

[sv/lqtl_checker.sv]
// Port-level checker for the lexer and its bind to the top level.
`timescale 1ns / 1ps

module lqtl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // Line ends and aborts carry no byte and no quoted flag.
  a_ctrl_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser[1:0] == lqtl_pkg::K_LEND) || (out_tuser[1:0] == lqtl_pkg::K_LONG))
      |-> (out_tdata == 8'd0) && !out_tuser[2])
    else $error("line end or abort with payload");

  // A line end is always the final result of its byte.
  a_lend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == lqtl_pkg::K_LEND) |-> out_tlast)
    else $error("line end not marked last");

  // The rest of a byte's results follows without a gap.
  a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("result group broken");

endmodule

bind line_and_quoted_token_lexer lqtl_checker u_lqtl_checker (.*);

[bench/tb.sv]
// Self-checking testbench for the line and quoted-token lexer.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LINE_MAX    = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;    // [7:0] out_byte
  logic [2:0]  out_tuser;    // [1:0] kind, [2] quoted
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [10:0] cfg_data;     // [10:0] line_limit

  // Sender and receiver pacing: 0 no idling, 1 random gaps, 2 rare long gaps.
  int          tx_mode;
  int          rx_mode;
  // Cycles the receiver still has to hold off; set by the stimulus for a long stall and by the receiver in mode 2.
  int          hold_left;
  int unsigned items_sent;
  int unsigned limit_writes;
  int unsigned cycle_count;

  // Predicts the lexer's results and checks them in order of arrival.
  class token_scoreboard;
    lqtl_pkg::result_t predicted[$];
    int unsigned limit;
    logic [1:0]  mode;
    logic        single_q;
    logic        cr_held;
    int unsigned line_len;
    int unsigned errors;
    int unsigned kind_seen[4];

    function new();
      limit  = LINE_MAX;
      errors = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      clear_line();
    endfunction

    function void clear_line();
      mode     = lqtl_pkg::M_IDLE;
      single_q = 1'b0;
      cr_held  = 1'b0;
      line_len = 0;
    endfunction

    function void add(logic [1:0] kind, logic [7:0] data, logic quoted);
      lqtl_pkg::result_t r;
      r.kind     = kind;
      r.out_byte = data;
      r.quoted   = quoted;
      r.last     = 1'b0;
      predicted.push_back(r);
    endfunction

    function void set_limit(logic [10:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return predicted.size();
    endfunction

    // One byte of line content, after CR handling.
    function void lex_text(logic [7:0] c);
      logic delim;
      logic [7:0] esc;
      delim = (c == lqtl_pkg::CH_SPACE) || (c == lqtl_pkg::CH_TAB);
      case (mode)
        lqtl_pkg::M_IDLE: begin
          if (delim) begin
          end else if (c == lqtl_pkg::CH_DQ || c == lqtl_pkg::CH_SQ) begin
            mode     = lqtl_pkg::M_QUOT;
            single_q = (c == lqtl_pkg::CH_SQ);
          end else begin
            mode = lqtl_pkg::M_BARE;
            add(lqtl_pkg::K_BYTE, c, 1'b0);
          end
        end
        lqtl_pkg::M_BARE: begin
          if (delim) begin
            add(lqtl_pkg::K_TEND, 8'h00, 1'b0);
            mode = lqtl_pkg::M_IDLE;
          end else begin
            add(lqtl_pkg::K_BYTE, c, 1'b0);
          end
        end
        lqtl_pkg::M_QUOT: begin
          if (c == (single_q ? lqtl_pkg::CH_SQ : lqtl_pkg::CH_DQ)) begin
            add(lqtl_pkg::K_TEND, 8'h00, 1'b1);
            mode = lqtl_pkg::M_IDLE;
          end else if (c == lqtl_pkg::CH_BSL) begin
            mode = lqtl_pkg::M_ESC;
          end else begin
            add(lqtl_pkg::K_BYTE, c, 1'b1);
          end
        end
        default: begin
          esc = c;
          if (c == lqtl_pkg::CH_N) esc = lqtl_pkg::CH_LF;
          else if (c == lqtl_pkg::CH_R) esc = lqtl_pkg::CH_CR;
          add(lqtl_pkg::K_BYTE, esc, 1'b1);
          mode = lqtl_pkg::M_QUOT;
        end
      endcase
    endfunction

    // An LF closes any open token, then the line.
    function void end_line();
      if (mode == lqtl_pkg::M_BARE) begin
        add(lqtl_pkg::K_TEND, 8'h00, 1'b0);
      end else if (mode == lqtl_pkg::M_QUOT) begin
        add(lqtl_pkg::K_TEND, 8'h00, 1'b1);
      end else if (mode == lqtl_pkg::M_ESC) begin
        add(lqtl_pkg::K_BYTE, lqtl_pkg::CH_BSL, 1'b1);
        add(lqtl_pkg::K_TEND, 8'h00, 1'b1);
      end
      add(lqtl_pkg::K_LEND, 8'h00, 1'b0);
      clear_line();
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(logic [7:0] b);
      int unsigned eff;
      int unsigned n0;
      lqtl_pkg::result_t r;
      eff = limit;
      if (eff < lqtl_pkg::MIN_LIMIT) eff = lqtl_pkg::MIN_LIMIT;
      if (eff > LINE_MAX) eff = LINE_MAX;
      n0 = predicted.size();
      if (line_len >= eff) begin
        add(lqtl_pkg::K_LONG, 8'h00, 1'b0);
        clear_line();
      end
      if (b == lqtl_pkg::CH_LF) begin
        end_line();
      end else begin
        if (cr_held) begin
          cr_held = 1'b0;
          lex_text(lqtl_pkg::CH_CR);
        end
        if (b == lqtl_pkg::CH_CR) cr_held = 1'b1;
        else lex_text(b);
        line_len++;
      end
      // The last result of this byte carries the last flag.
      if (predicted.size() > n0) begin
        r = predicted.pop_back();
        r.last = 1'b1;
        predicted.push_back(r);
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_result(logic [1:0] kind, logic [7:0] data, logic quoted, logic last);
      lqtl_pkg::result_t want;
      if (!$isunknown(kind)) kind_seen[kind]++;
      if (predicted.size() == 0) begin
        $error("result with no expectation waiting: kind %0d, out_byte 0x%02h", kind, data);
        errors++;
        return;
      end
      want = predicted.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (data !== want.out_byte) begin
        $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, data);
        errors++;
      end
      if (quoted !== want.quoted) begin
        $error("quoted: expected %0d, got %0d", want.quoted, quoted);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction

    function void final_check();
      if (predicted.size() != 0) begin
        $error("%0d expected results never arrived", predicted.size());
        errors++;
      end
    endfunction
  endclass

  token_scoreboard board = new();

  line_and_quoted_token_lexer #(
    .MAX_LINE(LINE_MAX)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Transaction monitors on all three channels.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_byte(in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tuser[1:0], out_tdata, out_tuser[2], out_tlast);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      board.set_limit(cfg_data);
      limit_writes++;
    end
  end

  // Receiver: ready pattern by mode, plus the long hold-off when one is requested.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_mode == 0) begin
        out_tready <= 1'b1;
      end else if (rx_mode == 1) begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        if ($urandom_range(0, 40) == 0) hold_left = $urandom_range(10, 40);
        out_tready <= (hold_left == 0) && ($urandom_range(0, 4) != 0);
      end
    end
  end

  // Sender gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int k;
    if (tx_mode == 0) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 50);
  endfunction

  // Byte mix that favors letters, separators, quotes and escapes.
  function automatic logic [7:0] random_text_byte();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 8'($urandom_range(8'h61, 8'h7A));
    if (k < 55) return ($urandom_range(0, 1) != 0) ? lqtl_pkg::CH_SPACE : lqtl_pkg::CH_TAB;
    if (k < 63) return ($urandom_range(0, 1) != 0) ? lqtl_pkg::CH_DQ : lqtl_pkg::CH_SQ;
    if (k < 70) return lqtl_pkg::CH_BSL;
    if (k < 74) return ($urandom_range(0, 1) != 0) ? lqtl_pkg::CH_N : lqtl_pkg::CH_R;
    if (k < 78) return lqtl_pkg::CH_CR;
    if (k < 80) return lqtl_pkg::CH_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A line of random content; most end in LF, some in CR LF, some run on.
  task automatic send_random_line();
    int len;
    int k;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(14, 30);
    for (int i = 0; i < len; i++) send_byte(random_text_byte());
    k = $urandom_range(0, 99);
    if (k < 15) send_byte(lqtl_pkg::CH_CR);
    if (k < 85) send_byte(lqtl_pkg::CH_LF);
  endtask

  task automatic send_lines(input int unsigned count);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < count) send_random_line();
  endtask

  // Printable text without any line break, then one LF.
  task automatic send_long_line(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_byte(($urandom_range(0, 7) == 0) ? lqtl_pkg::CH_SPACE :
                8'($urandom_range(8'h21, 8'h7E)));
    send_byte(lqtl_pkg::CH_LF);
  endtask

  // Waits until every expected result has arrived and the block has gone quiet.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [10:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus.
  initial begin : stimulus
    logic [7:0] opening_text [26];
    // Bytes at the field extremes and a quote inside a bare token, separators,
    // an empty quoted pair, a single-quoted token with every escape form, text
    // right after a closing quote, CR CR LF, a backslash ending the line, and a
    // lone quote before the line end.
    opening_text = '{"A", 8'h00, 8'hFF, lqtl_pkg::CH_DQ, lqtl_pkg::CH_SPACE,
                     lqtl_pkg::CH_TAB, lqtl_pkg::CH_DQ, lqtl_pkg::CH_DQ,
                     lqtl_pkg::CH_SQ, "a", lqtl_pkg::CH_BSL, lqtl_pkg::CH_N,
                     lqtl_pkg::CH_BSL, lqtl_pkg::CH_R, lqtl_pkg::CH_BSL, "x",
                     lqtl_pkg::CH_SQ, "z", lqtl_pkg::CH_CR, lqtl_pkg::CH_CR,
                     lqtl_pkg::CH_LF, lqtl_pkg::CH_DQ, lqtl_pkg::CH_BSL,
                     lqtl_pkg::CH_LF, lqtl_pkg::CH_SQ, lqtl_pkg::CH_LF};
    in_tvalid    <= 1'b0;
    in_tdata     <= 8'h00;
    cfg_valid    <= 1'b0;
    cfg_data     <= 11'd0;
    rst_n        <= 1'b0;
    tx_mode      = 1;
    rx_mode      = 1;
    hold_left    = 0;
    items_sent   = 0;
    limit_writes = 0;
    cycle_count  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset limit.
    foreach (opening_text[i]) send_byte(opening_text[i]);
    drain_block();

    // Smallest limit, so longer random lines get aborted.
    rx_mode = 2;
    write_limit(11'd16);
    send_lines(10);
    drain_block();

    // Limit below range; the receiver holds off while bytes keep coming.
    write_limit(11'd0);
    tx_mode   = 0;
    hold_left = 300;
    send_lines(15);
    drain_block();

    // No idling on either side.
    rx_mode = 0;
    write_limit(11'd17);
    send_lines(8);
    drain_block();

    tx_mode = 1;
    rx_mode = 1;
    write_limit(11'd15);
    send_lines(6);
    drain_block();

    write_limit(11'($urandom_range(18, 1023)));
    send_lines(6);
    drain_block();

    // Limit above range clamps to the maximum.
    tx_mode = 0;
    rx_mode = 0;
    write_limit(11'd2047);
    send_long_line(12);
    drain_block();

    tx_mode = 1;
    rx_mode = 2;
    write_limit(11'(LINE_MAX));
    send_lines(5);
    drain_block();
    repeat (16) @(posedge clk);

    board.final_check();
    $display("Lexed %0d input bytes over %0d line limit settings.", items_sent, limit_writes);
    $display("Results seen: %0d token bytes, %0d token ends, %0d line ends, %0d aborts.",
             board.kind_seen[lqtl_pkg::K_BYTE], board.kind_seen[lqtl_pkg::K_TEND],
             board.kind_seen[lqtl_pkg::K_LEND], board.kind_seen[lqtl_pkg::K_LONG]);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
